// File: sv/frst_pkg.sv
// shared constants, types and command/status structs for the range-sum table
package frst_pkg;

    localparam int unsigned FRST_SIZE = 1024;
    localparam int unsigned IDX_W     = 10;
    localparam int unsigned DATA_W    = 64;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_RANGE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SUM_HI,
        ST_SUM_LO,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic ready;
        logic accept;
        logic clear;
        logic add_rd;
        logic add_wr;
        logic walk;
        logic walk_neg;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic req_valid;
        logic req_func;
        logic req_oob;
        logic clr_last;
        logic add_last;
        logic t_zero;
        logic out_busy;
    } t_sts;

endpackage

// File: sv/frst_if.sv
// request and response channel interfaces of the range-sum table
interface frst_req_if
    import frst_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [IDX_W-1:0]         index;
    logic [IDX_W-1:0]         from_index;
    logic signed [DATA_W-1:0] delta;

    modport source (output valid, output func, output index, output from_index,
                    output delta, input ready);
    modport sink   (input valid, input func, input index, input from_index,
                    input delta, output ready);
endinterface

interface frst_rsp_if
    import frst_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] range_sum;

    modport source (output valid, output range_sum, input ready);
    modport sink   (input valid, input range_sum, output ready);
endinterface

// File: sv/frst_ctrl.sv
// sequencer for clearing, add walks and range-sum walks
module frst_ctrl
    import frst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_sts.req_valid) begin
                    if (i_sts.req_func == FUNC_RANGE) begin
                        n_state = ST_SUM_HI;
                    end else if (!i_sts.req_oob) begin
                        n_state = ST_ADD_RD;
                    end
                end
            end
            ST_ADD_RD: n_state = ST_ADD_WR;
            ST_ADD_WR: begin
                n_state = i_sts.add_last ? ST_IDLE : ST_ADD_RD;
            end
            ST_SUM_HI: begin
                if (i_sts.t_zero) n_state = ST_SUM_LO;
            end
            ST_SUM_LO: begin
                if (i_sts.t_zero) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_sts.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_CLEAR:  o_cmd.clear = 1'b1;
            ST_IDLE: begin
                o_cmd.ready  = 1'b1;
                o_cmd.accept = i_sts.req_valid;
            end
            ST_ADD_RD: o_cmd.add_rd = 1'b1;
            ST_ADD_WR: o_cmd.add_wr = 1'b1;
            ST_SUM_HI: o_cmd.walk = 1'b1;
            ST_SUM_LO: begin
                o_cmd.walk     = 1'b1;
                o_cmd.walk_neg = 1'b1;
            end
            ST_DONE:   o_cmd.load_out = !i_sts.out_busy;
            default:   o_cmd = '0;
        endcase
    end

endmodule

// File: sv/frst_datapath.sv
// node store, walk counter, accumulator and result register
module frst_datapath
    import frst_pkg::*;
#(
    parameter int unsigned SIZE = FRST_SIZE
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic                     i_req_valid,
    input  logic                     i_func,
    input  logic [IDX_W-1:0]         i_index,
    input  logic [IDX_W-1:0]         i_from_index,
    input  logic signed [DATA_W-1:0] i_delta,
    input  logic                     i_out_ready,
    output t_sts                     o_sts,
    output logic                     o_out_valid,
    output logic signed [DATA_W-1:0] o_range_sum
);

    localparam int unsigned AW = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int unsigned TW = $clog2(SIZE + 1);
    localparam int unsigned CW = (TW > IDX_W) ? TW : IDX_W;

    logic [DATA_W-1:0] r_mem [SIZE];
    logic [DATA_W-1:0] r_rdata;
    logic [AW-1:0]     r_clr;
    logic [TW-1:0]     r_t;
    logic [TW-1:0]     r_lo;
    logic [DATA_W-1:0] r_delta;
    logic [DATA_W-1:0] r_acc;
    logic              r_rd_vld;
    logic              r_rd_neg;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    logic [CW-1:0] hi_ext;
    logic [CW-1:0] lo_ext;
    logic [CW-1:0] hi_cl;
    logic [CW-1:0] lo_cl;
    logic          hi_oob;
    logic [TW-1:0] lb;
    logic [TW:0]   t_up;
    logic [TW-1:0] t_down;
    logic [AW-1:0] node_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [DATA_W-1:0] mem_wd;

    // saturate range endpoints, flag adds past the table
    always_comb begin
        hi_ext = CW'(i_index);
        lo_ext = CW'(i_from_index);
        hi_oob = (hi_ext >= CW'(SIZE));
        hi_cl  = hi_oob ? CW'(SIZE - 1) : hi_ext;
        lo_cl  = (lo_ext >= CW'(SIZE)) ? CW'(SIZE - 1) : lo_ext;
    end

    assign lb        = r_t & (~r_t + TW'(1));
    assign t_up      = {1'b0, r_t} + {1'b0, lb};
    assign t_down    = r_t - lb;
    assign node_addr = AW'(r_t - TW'(1));

    assign mem_we = i_cmd.clear | i_cmd.add_wr;
    assign mem_wa = i_cmd.clear ? r_clr : node_addr;
    assign mem_wd = i_cmd.clear ? '0 : (r_rdata + r_delta);

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[node_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_t     <= (i_func == FUNC_RANGE) ? (TW'(hi_cl) + TW'(1))
                                              : (TW'(hi_ext) + TW'(1));
            r_lo    <= TW'(lo_cl);
            r_delta <= i_delta;
        end else if (i_cmd.add_wr) begin
            r_t <= TW'(t_up);
        end else if (i_cmd.walk) begin
            if (r_t != '0) begin
                r_t <= t_down;
            end else if (!i_cmd.walk_neg) begin
                r_t <= r_lo;
            end
        end
        if (i_cmd.walk) r_rd_neg <= i_cmd.walk_neg;
        if (i_cmd.accept) begin
            r_acc <= '0;
        end else if (r_rd_vld) begin
            r_acc <= r_rd_neg ? (r_acc - r_rdata) : (r_acc + r_rdata);
        end
        if (i_cmd.load_out) r_out_data <= r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) r_clr <= r_clr + AW'(1);
            r_rd_vld <= i_cmd.walk && (r_t != '0);
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.req_valid = i_req_valid;
        o_sts.req_func  = i_func;
        o_sts.req_oob   = hi_oob;
        o_sts.clr_last  = (r_clr == AW'(SIZE - 1));
        o_sts.add_last  = (t_up > (TW + 1)'(SIZE));
        o_sts.t_zero    = (r_t == '0);
        o_sts.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_out_data;

`ifndef SYNTHESIS
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clear, i_cmd.accept, i_cmd.walk, i_cmd.add_rd,
                  i_cmd.add_wr, i_cmd.load_out}))
        else $error("more than one datapath command at once");
    a_add_node_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.add_rd || i_cmd.add_wr) |-> (r_t != '0 && r_t <= TW'(SIZE)))
        else $error("add walk outside node range");
    a_rd_follows_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(i_cmd.walk))
        else $error("read data marked valid without a walk step");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_out_valid && !i_out_ready))
        else $error("result register loaded while a beat is pending");
`endif

endmodule

// File: sv/fenwick_range_sum_table.sv
// top level of the binary indexed range-sum table
//
// usage
// - i_req carries one beat per item: func 0 adds delta at index (no response),
//   func 1 returns the sum of positions from_index..index on o_rsp
// - index/from_index at or past SIZE: an add is dropped, a range endpoint
//   saturates to SIZE-1; a reversed range still gives prefix(hi)-prefix(lo-1)
// - all sums wrap modulo 2^64
// timing
// - after reset the node store is swept to zero, one entry a cycle, and
//   i_req.ready stays low until the sweep is done
// - one item at a time; ready is high only while the sequencer is idle
// - add: an accept step, then for each node on the upward lowbit chain
//   a read then a write through the single store port
// - range: an accept step, a walk down the nodes of hi and then of lo with
//   one store read per cycle, and a step to load the result register
// - the result sits in an output register; if o_rsp is stalled the next
//   item is still taken, and only a range item finishing before the
//   pending beat is taken waits for it
module fenwick_range_sum_table
    import frst_pkg::*;
#(
    parameter int unsigned SIZE = FRST_SIZE
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    frst_req_if.sink       i_req,
    frst_rsp_if.source     o_rsp
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: owns the handshake on the request side
    frst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // node store and arithmetic
    frst_datapath #(
        .SIZE (SIZE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_valid  (i_req.valid),
        .i_func       (i_req.func),
        .i_index      (i_req.index),
        .i_from_index (i_req.from_index),
        .i_delta      (i_req.delta),
        .i_out_ready  (o_rsp.ready),
        .o_sts        (sts),
        .o_out_valid  (o_rsp.valid),
        .o_range_sum  (o_rsp.range_sum)
    );

    // request beat is taken whenever the sequencer is idle
    assign i_req.ready = cmd.ready;

endmodule

// File: dv/frst_range_sum_checker.sv
`timescale 1ns / 1ps
// checker for the range-sum table: predicts range sums from request beats, compares responses
module frst_range_sum_checker
    import frst_pkg::*;
#(
    parameter int unsigned SIZE = FRST_SIZE
) (
    input  logic i_clk,
    input  logic i_rst_n,
    frst_req_if  req_mon,
    frst_rsp_if  rsp_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    // own copy of the node store, slot t-1 holds tree node t
    logic [DATA_W-1:0] node_sum [SIZE];
    logic [DATA_W-1:0] expected_sums [$];

    function automatic int unsigned lowbit(int unsigned t);
        return t & (~t + 1);
    endfunction

    function automatic int unsigned clamp_pos(logic [IDX_W-1:0] p);
        return (p >= SIZE) ? SIZE - 1 : int'(p);
    endfunction

    function automatic void add_delta(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] delta);
        int unsigned t;
        if (idx >= SIZE) return;
        for (t = idx + 1; t <= SIZE; t += lowbit(t))
            node_sum[t-1] += delta;
    endfunction

    function automatic logic [DATA_W-1:0] prefix_total(int unsigned count);
        logic [DATA_W-1:0] acc;
        int unsigned       t;
        acc = '0;
        t   = count;
        while (t > 0) begin
            acc += node_sum[t-1];
            t   -= lowbit(t);
        end
        return acc;
    endfunction

    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        if (!i_rst_n) begin
            foreach (node_sum[k]) node_sum[k] = '0;
            expected_sums.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            // response first: it always belongs to an earlier request
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (expected_sums.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected range_sum beat %0d", $time,
                                 rsp_mon.range_sum);
                end else begin
                    want = expected_sums.pop_front();
                    o_checked++;
                    if (rsp_mon.range_sum !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: range_sum expected %0d got %0d", $time,
                                     $signed(want), rsp_mon.range_sum);
                    end
                end
            end
            if (req_mon.valid && req_mon.ready) begin
                if (req_mon.func == FUNC_ADD)
                    add_delta(req_mon.index, req_mon.delta);
                else
                    expected_sums.push_back(
                        prefix_total(clamp_pos(req_mon.index) + 1)
                        - prefix_total(clamp_pos(req_mon.from_index)));
            end
        end
        o_pending = expected_sums.size();
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// top of the range-sum table testbench: clock, reset, stimulus, stalls and verdict
module testbench;
    import frst_pkg::*;

    logic i_clk;
    logic i_rst_n;

    frst_req_if req_ch ();
    frst_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int checked;

    // percent of cycles the sender idles / the receiver stalls, per phase
    int idle_pct;
    int stall_pct;

    int add_count;
    int range_count;

    fenwick_range_sum_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    frst_range_sum_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_mon      (req_ch),
        .rsp_mon      (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // receiver back-pressure, one decision per falling edge
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // drive one request beat and hold it until the block takes it
    task automatic send_item(logic func, logic [IDX_W-1:0] idx,
                             logic [IDX_W-1:0] from_idx, logic [DATA_W-1:0] delta);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            // idle cycle with junk on the payload
            req_ch.valid      <= 1'b0;
            req_ch.func       <= 1'($urandom_range(1));
            req_ch.index      <= IDX_W'($urandom);
            req_ch.from_index <= IDX_W'($urandom);
            req_ch.delta      <= {$urandom, $urandom};
            @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= func;
        req_ch.index      <= idx;
        req_ch.from_index <= from_idx;
        req_ch.delta      <= delta;
        do @(posedge i_clk); while (!req_ch.ready);
        if (func == FUNC_ADD) add_count++;
        else range_count++;
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return IDX_W'(1 << $urandom_range(IDX_W - 1));
            3:       return IDX_W'((1 << $urandom_range(IDX_W - 1)) - 1);
            default: return IDX_W'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_delta();
        case ($urandom_range(5))
            0:       return {1'b0, {(DATA_W-1){1'b1}}};
            1:       return {1'b1, {(DATA_W-1){1'b0}}};
            2:       return '1;
            3:       return DATA_W'($signed($urandom_range(2000)) - 1000);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_random();
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] lo;
        hi = pick_index();
        lo = pick_index();
        if ($urandom_range(1) == 0) begin
            send_item(FUNC_ADD, hi, lo, pick_delta());
        end else begin
            // mostly well-ordered ranges, some prefix-only and some reversed
            case ($urandom_range(5))
                0:       lo = '0;
                1:       ;
                default: if (lo > hi) {lo, hi} = {hi, lo};
            endcase
            send_item(FUNC_RANGE, hi, lo, {$urandom, $urandom});
        end
    endtask

    initial begin
        req_ch.valid      = 1'b0;
        req_ch.func       = FUNC_ADD;
        req_ch.index      = '0;
        req_ch.from_index = '0;
        req_ch.delta      = '0;
        idle_pct          = 0;
        stall_pct         = 0;
        add_count         = 0;
        range_count       = 0;
        i_rst_n           = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, wrap, reversed and single-slot ranges
        send_item(FUNC_RANGE, '1, '0, '0);
        send_item(FUNC_ADD, '0, '1, {1'b0, {(DATA_W-1){1'b1}}});
        send_item(FUNC_ADD, '1, '0, {1'b1, {(DATA_W-1){1'b0}}});
        send_item(FUNC_ADD, 10'd512, '0, '1);
        send_item(FUNC_ADD, 10'd1, '0, 64'd1);
        send_item(FUNC_ADD, 10'd511, '0, 64'd77);
        send_item(FUNC_RANGE, '1, '0, '0);
        send_item(FUNC_RANGE, '0, '0, '0);
        send_item(FUNC_RANGE, '1, '1, '0);
        send_item(FUNC_RANGE, '0, '1, '0);
        send_item(FUNC_RANGE, 10'd3, 10'd5, '0);
        send_item(FUNC_RANGE, 10'd511, 10'd512, '0);
        send_item(FUNC_RANGE, 10'd511, '0, '0);
        send_item(FUNC_RANGE, 10'd512, 10'd512, '0);
        send_item(FUNC_ADD, '0, '0, 64'd1);
        send_item(FUNC_RANGE, '0, '0, '0);
        send_item(FUNC_ADD, '1, '0, '1);
        send_item(FUNC_RANGE, '1, 10'd1023, '0);
        send_item(FUNC_RANGE, 10'd1022, 10'd1, '0);
        send_item(FUNC_RANGE, '1, '0, '1);

        // random phases: free flow, slow sender, slow receiver, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            repeat (200) send_random();
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        stall_pct = 15;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("run covered %0d adds and %0d range sums, %0d sums compared",
                 add_count, range_count, checked);
        $display("phases: free flow, 80%% sender idle, 80%% receiver stall, 15%% both");
        if (fail_count == 0 && pending == 0) begin
            $display("fenwick_range_sum_table: match");
        end else begin
            $display("fenwick_range_sum_table: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("timeout with %0d sums outstanding", pending);
        $display("fenwick_range_sum_table: mismatch");
        $finish;
    end

endmodule
